// File: rtl/core/chs_pkg.sv
// Package for the chained hash set: sizes, state codes, command and status structs.
// Used by chs_ctrl, chs_dp and chained_hash_set; depends on nothing.
`default_nettype none
package chs_pkg;
    localparam int MAX_BUCKETS = 4096;
    localparam int MAX_ENTRIES = 4096;
    localparam int KEY_BITS    = 31;
    localparam int CNT_W       = 13;                 // holds 0..MAX_ENTRIES
    localparam int IDX_W       = 12;                 // addresses an entry or a bucket
    localparam int SIZE_REGS   = 6;
    localparam int CFG_AW      = 3;
    localparam int STEP_W      = 3;
    localparam int DIV_CNT_W   = 5;
    localparam int DATA_W      = 32;                 // key padded to whole bytes
    localparam int OUT_W       = 32;

    localparam logic [CNT_W-1:0] CFG_RESET [SIZE_REGS] = '{
        13'd1021, 13'd1531, 13'd2039, 13'd2557, 13'd3067, 13'd4093
    };
    localparam logic [CFG_AW-1:0] REG_INITIAL = 3'd0;
    localparam logic [STEP_W-1:0] LAST_STEP   = 3'd5;
    localparam logic              KIND_INSERT = 1'b0;

    typedef enum logic [3:0] {
        ST_CLR_BOOT, ST_IDLE, ST_DIV, ST_HWT, ST_WALK, ST_EWT, ST_DECIDE, ST_LINK,
        ST_CHECK, ST_CLR_GROW, ST_RH_CHK, ST_RH_WT, ST_RH_DIV, ST_RH_HWT, ST_RH_LINK,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic load_item;
        logic div_item;
        logic div_ram;
        logic head_load;
        logic ent_rd;
        logic walk_step;
        logic app_ent;
        logic app_link;
        logic set_full;
        logic grow;
        logic clr_step;
        logic rh_rd;
        logic rh_link;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic div_done;
        logic walk_end;
        logic match;
        logic is_insert;
        logic found;
        logic pool_full;
        logic need_grow;
        logic clr_last;
        logic rh_end;
        logic out_free;
    } sts_t;

    function automatic logic [CNT_W-1:0] clamp_size(input logic [CNT_W-1:0] v);
        if (v == '0) begin
            return CNT_W'(1);
        end else if (v > CNT_W'(MAX_BUCKETS)) begin
            return CNT_W'(MAX_BUCKETS);
        end
        return v;
    endfunction
endpackage
`default_nettype wire

// File: rtl/core/chs_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Standalone; no package needed.
`default_nettype none
module chs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// File: rtl/core/chs_ctrl.sv
// Controller for the chained hash set: sequences lookup, append, growth and rehash.
// Depends on chs_pkg.
`default_nettype none
module chs_ctrl (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    input  wire chs_pkg::sts_t sts,
    output chs_pkg::cmd_t      cmd
);
    chs_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= chs_pkg::ST_CLR_BOOT;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            chs_pkg::ST_CLR_BOOT: begin
                cmd.clr_step = 1'b1;
                if (sts.clr_last) state_next = chs_pkg::ST_IDLE;
            end
            chs_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load_item = 1'b1;
                    cmd.div_item  = 1'b1;
                    state_next    = chs_pkg::ST_DIV;
                end
            end
            chs_pkg::ST_DIV: begin
                if (sts.div_done) state_next = chs_pkg::ST_HWT;
            end
            chs_pkg::ST_HWT: begin
                cmd.head_load = 1'b1;
                state_next    = chs_pkg::ST_WALK;
            end
            chs_pkg::ST_WALK: begin
                if (sts.walk_end) begin
                    state_next = chs_pkg::ST_DECIDE;
                end else begin
                    cmd.ent_rd = 1'b1;
                    state_next = chs_pkg::ST_EWT;
                end
            end
            chs_pkg::ST_EWT: begin
                cmd.walk_step = 1'b1;
                state_next    = sts.match ? chs_pkg::ST_DECIDE : chs_pkg::ST_WALK;
            end
            chs_pkg::ST_DECIDE: begin
                if (sts.is_insert && !sts.found) begin
                    if (sts.pool_full) begin
                        cmd.set_full = 1'b1;
                        state_next   = chs_pkg::ST_DONE;
                    end else begin
                        cmd.app_ent = 1'b1;
                        state_next  = chs_pkg::ST_LINK;
                    end
                end else begin
                    state_next = chs_pkg::ST_DONE;
                end
            end
            chs_pkg::ST_LINK: begin
                cmd.app_link = 1'b1;
                state_next   = chs_pkg::ST_CHECK;
            end
            chs_pkg::ST_CHECK: begin
                if (sts.need_grow) begin
                    cmd.grow   = 1'b1;
                    state_next = chs_pkg::ST_CLR_GROW;
                end else begin
                    state_next = chs_pkg::ST_DONE;
                end
            end
            chs_pkg::ST_CLR_GROW: begin
                cmd.clr_step = 1'b1;
                if (sts.clr_last) state_next = chs_pkg::ST_RH_CHK;
            end
            chs_pkg::ST_RH_CHK: begin
                if (sts.rh_end) begin
                    state_next = chs_pkg::ST_DONE;
                end else begin
                    cmd.rh_rd  = 1'b1;
                    state_next = chs_pkg::ST_RH_WT;
                end
            end
            chs_pkg::ST_RH_WT: begin
                cmd.div_ram = 1'b1;
                state_next  = chs_pkg::ST_RH_DIV;
            end
            chs_pkg::ST_RH_DIV: begin
                if (sts.div_done) state_next = chs_pkg::ST_RH_HWT;
            end
            chs_pkg::ST_RH_HWT: begin
                state_next = chs_pkg::ST_RH_LINK;
            end
            chs_pkg::ST_RH_LINK: begin
                cmd.rh_link = 1'b1;
                state_next  = chs_pkg::ST_RH_CHK;
            end
            chs_pkg::ST_DONE: begin
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = chs_pkg::ST_IDLE;
                end
            end
            default: state_next = chs_pkg::ST_CLR_BOOT;
        endcase
    end
endmodule
`default_nettype wire

// File: rtl/core/chs_dp.sv
// Datapath for the chained hash set: size registers, bit-serial modulo unit,
// bucket-head and entry memories, chain walk registers and result register.
// Depends on chs_pkg and chs_ram.
`default_nettype none
module chs_dp (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire chs_pkg::cmd_t                 cmd,
    output chs_pkg::sts_t                      sts,
    input  wire logic                          item_kind,
    input  wire logic [chs_pkg::KEY_BITS-1:0]  item_key,
    input  wire logic                          cfg_we,
    input  wire logic [chs_pkg::CFG_AW-1:0]    cfg_addr,
    input  wire logic [chs_pkg::CNT_W-1:0]     cfg_data,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [chs_pkg::OUT_W-1:0]          out_data
);
    localparam int KB = chs_pkg::KEY_BITS;
    localparam int CW = chs_pkg::CNT_W;
    localparam int IW = chs_pkg::IDX_W;

    logic [CW-1:0] cfg_reg [chs_pkg::SIZE_REGS];
    logic [CW-1:0] buckets_reg, count_reg;
    logic [chs_pkg::STEP_W-1:0] step_reg;

    logic [KB-1:0] key_reg;
    logic          kind_reg;
    logic [KB-1:0] dvd_reg;
    logic [CW-1:0] rem_reg;
    logic [chs_pkg::DIV_CNT_W-1:0] div_cnt_reg;

    logic [CW-1:0] cur_reg, last_reg, hops_reg, rh_idx_reg;
    logic [IW-1:0] clr_idx_reg;
    logic          found_reg, added_reg, grew_reg, full_reg;
    logic          out_valid_reg;
    logic [chs_pkg::OUT_W-1:0] out_data_reg;

    // memories
    logic          head_we, next_we, key_we;
    logic [IW-1:0] head_waddr, next_waddr, key_raddr, ent_idx;
    logic [CW-1:0] head_wdata, next_wdata, head_rdata, next_rdata;
    logic [KB-1:0] key_rdata;

    logic [CW:0]   div_trial;
    logic [CW-1:0] cfg_next_size;

    assign ent_idx   = IW'(cur_reg - CW'(1));
    assign key_raddr = cmd.rh_rd ? rh_idx_reg[IW-1:0] : ent_idx;
    assign cfg_next_size = chs_pkg::clamp_size(cfg_reg[step_reg + chs_pkg::STEP_W'(1)]);

    always_comb begin
        head_we    = 1'b0;
        head_waddr = rem_reg[IW-1:0];
        head_wdata = '0;
        next_we    = 1'b0;
        next_waddr = count_reg[IW-1:0];
        next_wdata = '0;
        key_we     = cmd.app_ent;
        if (cmd.clr_step) begin
            head_we    = 1'b1;
            head_waddr = clr_idx_reg;
        end else if (cmd.app_link && last_reg == '0) begin
            head_we    = 1'b1;
            head_wdata = count_reg + CW'(1);
        end else if (cmd.rh_link) begin
            head_we    = 1'b1;
            head_wdata = rh_idx_reg + CW'(1);
        end
        if (cmd.app_ent) begin
            next_we = 1'b1;
        end else if (cmd.app_link && last_reg != '0) begin
            next_we    = 1'b1;
            next_waddr = IW'(last_reg - CW'(1));
            next_wdata = count_reg + CW'(1);
        end else if (cmd.rh_link) begin
            next_we    = 1'b1;
            next_waddr = rh_idx_reg[IW-1:0];
            next_wdata = head_rdata;
        end
    end

    chs_ram #(.WIDTH(CW), .DEPTH(chs_pkg::MAX_BUCKETS)) u_heads (
        .aclk(aclk), .we(head_we), .waddr(head_waddr), .wdata(head_wdata),
        .raddr(rem_reg[IW-1:0]), .rdata(head_rdata)
    );
    chs_ram #(.WIDTH(CW), .DEPTH(chs_pkg::MAX_ENTRIES)) u_next (
        .aclk(aclk), .we(next_we), .waddr(next_waddr), .wdata(next_wdata),
        .raddr(ent_idx), .rdata(next_rdata)
    );
    chs_ram #(.WIDTH(KB), .DEPTH(chs_pkg::MAX_ENTRIES)) u_keys (
        .aclk(aclk), .we(key_we), .waddr(count_reg[IW-1:0]), .wdata(key_reg),
        .raddr(key_raddr), .rdata(key_rdata)
    );

    // one quotient bit per cycle
    assign div_trial = {rem_reg, dvd_reg[KB-1]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < chs_pkg::SIZE_REGS; i++) cfg_reg[i] <= chs_pkg::CFG_RESET[i];
            buckets_reg   <= chs_pkg::clamp_size(chs_pkg::CFG_RESET[0]);
            count_reg     <= '0;
            step_reg      <= '0;
            div_cnt_reg   <= '0;
            clr_idx_reg   <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_we && cfg_addr < chs_pkg::CFG_AW'(chs_pkg::SIZE_REGS)) begin
                cfg_reg[cfg_addr] <= cfg_data;
                if (cfg_addr == chs_pkg::REG_INITIAL && count_reg == '0 && step_reg == '0) begin
                    buckets_reg <= chs_pkg::clamp_size(cfg_data);
                end
            end
            if (cmd.div_item || cmd.div_ram) begin
                div_cnt_reg <= chs_pkg::DIV_CNT_W'(KB);
            end else if (div_cnt_reg != '0) begin
                div_cnt_reg <= div_cnt_reg - chs_pkg::DIV_CNT_W'(1);
            end
            if (cmd.clr_step) clr_idx_reg <= clr_idx_reg + IW'(1);
            if (cmd.app_link) count_reg <= count_reg + CW'(1);
            if (cmd.grow) begin
                step_reg    <= step_reg + chs_pkg::STEP_W'(1);
                buckets_reg <= cfg_next_size;
            end
            if (cmd.out_load) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.div_item) begin
            dvd_reg <= item_key;
            rem_reg <= '0;
        end else if (cmd.div_ram) begin
            dvd_reg <= key_rdata;
            rem_reg <= '0;
        end else if (div_cnt_reg != '0) begin
            dvd_reg <= {dvd_reg[KB-2:0], 1'b0};
            if (div_trial >= {1'b0, buckets_reg}) begin
                rem_reg <= CW'(div_trial - {1'b0, buckets_reg});
            end else begin
                rem_reg <= div_trial[CW-1:0];
            end
        end
        if (cmd.load_item) begin
            key_reg   <= item_key;
            kind_reg  <= item_kind;
            last_reg  <= '0;
            hops_reg  <= '0;
            found_reg <= 1'b0;
            added_reg <= 1'b0;
            grew_reg  <= 1'b0;
            full_reg  <= 1'b0;
        end
        if (cmd.head_load) cur_reg <= head_rdata;
        if (cmd.walk_step) begin
            if (key_rdata == key_reg) begin
                found_reg <= 1'b1;
            end else begin
                last_reg <= cur_reg;
                cur_reg  <= next_rdata;
                hops_reg <= hops_reg + CW'(1);
            end
        end
        if (cmd.app_link) added_reg <= 1'b1;
        if (cmd.set_full) full_reg <= 1'b1;
        if (cmd.grow) begin
            grew_reg   <= 1'b1;
            rh_idx_reg <= '0;
        end
        if (cmd.rh_link) rh_idx_reg <= rh_idx_reg + CW'(1);
        if (cmd.out_load) begin
            out_data_reg <= {2'b00, count_reg, buckets_reg, full_reg, grew_reg, added_reg,
                             found_reg};
        end
    end

    always_comb begin
        sts.div_done  = (div_cnt_reg == '0);
        sts.walk_end  = (cur_reg == '0) || (cur_reg > count_reg) || (hops_reg >= count_reg);
        sts.match     = (key_rdata == key_reg);
        sts.is_insert = (kind_reg == chs_pkg::KIND_INSERT);
        sts.found     = found_reg;
        sts.pool_full = (count_reg == CW'(chs_pkg::MAX_ENTRIES));
        sts.need_grow = ({count_reg, 2'b00} >= (CW + 2)'(buckets_reg) * (CW + 2)'(3))
                        && (step_reg < chs_pkg::LAST_STEP);
        sts.clr_last  = (clr_idx_reg == '1);
        sts.rh_end    = (rh_idx_reg >= count_reg);
        sts.out_free  = !out_valid_reg || out_ready;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
endmodule
`default_nettype wire

// File: rtl/core/chained_hash_set.sv
// The bit-serial modulo unit takes one bit of the 31-bit key a cycle. Throughput: one item
// at a time. An insert that grows the table adds a clearing sweep of all 4096 bucket
// heads and a rehash of every stored key.
// Reset (aresetn low, synchronous): size registers take their defaults, the set empties,
// then a sweep clears all 4096 bucket heads while s_tready stays low.
`default_nettype none
module chained_hash_set (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    // input items
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [chs_pkg::DATA_W-1:0]     s_tdata,   // [30:0] key, [31] zero
    input  wire logic                           s_tuser,   // [0] kind: 0 insert, 1 search
    // result items
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic [chs_pkg::OUT_W-1:0]           m_tdata,   // [0] found, [1] added,
                                                           // [2] grew, [3] full,
                                                           // [16:4] bucket_total,
                                                           // [29:17] key_total, [31:30] 0
    // size register writes, always taken
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [chs_pkg::CFG_AW-1:0]     cfg_addr,
    input  wire logic [chs_pkg::CNT_W-1:0]      cfg_data
);
    chs_pkg::cmd_t cmd;
    chs_pkg::sts_t sts;

    assign cfg_ready = 1'b1;

    // sequence each item through lookup, append and growth
    chs_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready),
        .sts(sts), .cmd(cmd)
    );

    // hold the table, the modulo unit and the result register
    chs_dp u_dp (
        .aclk(aclk), .aresetn(aresetn),
        .cmd(cmd), .sts(sts),
        .item_kind(s_tuser), .item_key(s_tdata[chs_pkg::KEY_BITS-1:0]),
        .cfg_we(cfg_valid && cfg_ready), .cfg_addr(cfg_addr), .cfg_data(cfg_data),
        .out_valid(m_tvalid), .out_ready(m_tready), .out_data(m_tdata)
    );
endmodule
`default_nettype wire
